[design/asa_pkg.sv]
// ----------------------------------------------------------------------------
// Angle sample averager package
// Shared widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package asa_pkg;

  localparam int CHANNEL_COUNT_DEF = 2;
  localparam int MAX_READS_DEF     = 16;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int ANGLE_W   = 12;
  localparam int OFFSET_W  = 13;
  localparam int FAIL_W    = 5;
  localparam int HIGH_W    = 4;

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  localparam logic [FAIL_W-1:0] FAIL_SAT = '1;

  localparam logic [CFG_W-1:0] BASELINE_READS_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] MEASURE_READS_RST  = CFG_W'(5);
  localparam logic [CFG_W-1:0] FAILURE_LIMIT_RST  = CFG_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_READS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_READS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT  = CFG_IDX_W'(2);

  localparam logic KIND_BASELINE = 1'b0;
  localparam logic KIND_MEASURE  = 1'b1;

endpackage

[design/asa_div.sv]
// ----------------------------------------------------------------------------
// Angle sample averager divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asa_div #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {rem, quotient[SUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEP_W'(SUM_W);
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[CNT_W]) begin
          rem      <= diff[CNT_W-1:0];
          quotient <= {quotient[SUM_W-2:0], 1'b1};
        end else begin
          rem      <= trial[CNT_W-1:0];
          quotient <= {quotient[SUM_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/angle_sample_averager.sv]
// ----------------------------------------------------------------------------
// Angle sample averager
// Two-phase read bursts per channel: discard, then average (measure: vs baseline).
// Flow: a request that ends no burst leaves the block idle; an error result
//   goes through S_EMIT to m_tvalid; an average through S_DIV, where the shared
//   divider forms one quotient bit per cycle, and then S_EMIT.
// Throughput: one request per cycle inside a burst; s_tready drops at burst end.
// Reset (rst, synchronous): idle, baselines zero, registers 10 / 5 / 5.
// ----------------------------------------------------------------------------
module angle_sample_averager #(
  parameter int CHANNEL_COUNT = asa_pkg::CHANNEL_COUNT_DEF,
  parameter int MAX_READS     = asa_pkg::MAX_READS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [asa_pkg::S_TDATA_W-1:0]  s_tdata,   // angle_high, angle_low
  input  logic [asa_pkg::S_TUSER_W-1:0]  s_tuser,   // action, channel, read_ok
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [asa_pkg::M_TDATA_W-1:0]  m_tdata,   // position, offset, zero pad
  output logic [asa_pkg::M_TUSER_W-1:0]  m_tuser,   // out_channel, read_error
  input  logic                           cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asa_pkg::CFG_W-1:0]      cfg_data
);

  import asa_pkg::*;

  localparam int CNT_W = $clog2(MAX_READS + 1);
  localparam int SUM_W = $clog2(MAX_READS * ((1 << ANGLE_W) - 1) + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t                state;
  logic [CFG_W-1:0]      baseline_reads;
  logic [CFG_W-1:0]      measure_reads;
  logic [CFG_W-1:0]      failure_limit;
  logic [ANGLE_W-1:0]    baseline_angle [CHANNEL_COUNT];
  logic [SUM_W-1:0]      sample_sum;
  logic [CNT_W-1:0]      good_reads;
  logic [FAIL_W-1:0]     failed_reads;
  logic [CNT_W-1:0]      reads_in_phase;
  logic                  averaging_phase;
  logic                  burst_active;
  logic                  burst_kind;
  logic                  burst_channel;
  logic                  res_channel;
  logic                  res_error;
  logic [ANGLE_W-1:0]    res_position;
  logic [OFFSET_W-1:0]   res_offset;

  logic                  start;
  logic                  kind_c;
  logic                  ch_c;
  logic                  ok;
  logic [ANGLE_W-1:0]    angle;
  logic [FAIL_W-1:0]     fails0;
  logic [FAIL_W-1:0]     fails1;
  logic [SUM_W-1:0]      sum0;
  logic [SUM_W-1:0]      sum1;
  logic [CNT_W-1:0]      good0;
  logic [CNT_W-1:0]      good1;
  logic [CNT_W-1:0]      rip1;
  logic                  avg0;
  logic [CFG_W-1:0]      n_raw;
  logic [CNT_W-1:0]      n_cur;
  logic                  phase_end;
  logic                  fail_hit;
  logic                  go_div;
  logic [IDX_W-1:0]      idx;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      div_quo;
  logic [ANGLE_W-1:0]    pos;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    start  = !burst_active;
    kind_c = start ? s_tuser[0] : burst_kind;
    ch_c   = start ? s_tuser[1] : burst_channel;
    ok     = s_tuser[2];
    angle  = {s_tdata[HIGH_W-1:0], s_tdata[15:8]};
    fails0 = start ? '0 : failed_reads;
    sum0   = start ? '0 : sample_sum;
    good0  = start ? '0 : good_reads;
    avg0   = start ? 1'b0 : averaging_phase;
    rip1   = (start ? '0 : reads_in_phase) + CNT_W'(1);
    fails1 = (!ok && fails0 != FAIL_SAT) ? fails0 + FAIL_W'(1) : fails0;
    sum1   = sum0;
    good1  = good0;
    if (avg0 && ok) begin
      sum1  = sum0 + SUM_W'(angle);
      good1 = good0 + CNT_W'(1);
    end
    n_raw = (kind_c == KIND_MEASURE) ? measure_reads : baseline_reads;
    if (n_raw == '0) begin
      n_cur = CNT_W'(1);
    end else if (CMP_W'(n_raw) > CMP_W'(MAX_READS)) begin
      n_cur = CNT_W'(MAX_READS);
    end else begin
      n_cur = CNT_W'(n_raw);
    end
    phase_end = (rip1 >= n_cur);
    fail_hit  = (fails1 >= failure_limit) || (avg0 && good1 == '0);
    go_div    = phase_end && !fail_hit && avg0;
  end

  assign div_start = s_tvalid && s_tready && go_div;
  assign idx       = (CHANNEL_COUNT > 1) ? IDX_W'(burst_channel) : '0;
  assign pos       = div_quo[ANGLE_W-1:0];

  asa_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum1),
    .divisor  (good1),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      baseline_reads  <= BASELINE_READS_RST;
      measure_reads   <= MEASURE_READS_RST;
      failure_limit   <= FAILURE_LIMIT_RST;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        baseline_angle[i] <= '0;
      end
      sample_sum      <= '0;
      good_reads      <= '0;
      failed_reads    <= '0;
      reads_in_phase  <= '0;
      averaging_phase <= 1'b0;
      burst_active    <= 1'b0;
      burst_kind      <= 1'b0;
      burst_channel   <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASELINE_READS: baseline_reads <= cfg_data;
          REG_MEASURE_READS:  measure_reads  <= cfg_data;
          REG_FAILURE_LIMIT:  failure_limit  <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            burst_kind      <= kind_c;
            burst_channel   <= ch_c;
            sample_sum      <= sum1;
            good_reads      <= good1;
            failed_reads    <= fails1;
            reads_in_phase  <= rip1;
            averaging_phase <= avg0;
            burst_active    <= 1'b1;
            if (phase_end) begin
              if (fail_hit) begin
                burst_active <= 1'b0;
                res_channel  <= ch_c;
                res_error    <= 1'b1;
                res_position <= '0;
                res_offset   <= '0;
                state        <= S_EMIT;
              end else if (!avg0) begin
                averaging_phase <= 1'b1;
                reads_in_phase  <= '0;
                if (kind_c == KIND_MEASURE) begin
                  failed_reads <= '0;
                end
              end else begin
                burst_active <= 1'b0;
                res_channel  <= ch_c;
                res_error    <= 1'b0;
                state        <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_position <= pos;
            if (burst_kind == KIND_MEASURE) begin
              res_offset <= {1'b0, pos} - {1'b0, baseline_angle[idx]};
            end else begin
              baseline_angle[idx] <= pos;
              res_offset          <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_TDATA_W'({res_offset, res_position});
            m_tuser  <= {res_error, res_channel};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_no_burst_after_end: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !burst_active)
    else $error("burst still active while a result is pending");

  a_good_within_phase: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> good_reads <= reads_in_phase)
    else $error("good read count exceeds reads in phase");

  a_phase_count_bound: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> CMP_W'(reads_in_phase) < CMP_W'(MAX_READS))
    else $error("reads in phase beyond the maximum");
`endif

endmodule

[dv/tb_angle_sample_averager.sv]
// ----------------------------------------------------------------------------
// Angle sample averager testbench
// Streams angle reads into the block burst by burst. A scoreboard folds each
// accepted request into its own copy of the burst state. It checks every
// burst result field by field against the queued prediction. The run covers
// several register settings, idle and stall patterns on both stream sides,
// and one long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_angle_sample_averager;
  import asa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 25;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic       action;
    logic       channel;
    logic       read_ok;
    logic [7:0] angle_high;
    logic [7:0] angle_low;
  } angle_read_t;

  typedef struct packed {
    logic                channel;
    logic                error;
    logic [ANGLE_W-1:0]  position;
    logic [OFFSET_W-1:0] offset;
  } burst_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;  // angle_high, angle_low
  logic [S_TUSER_W-1:0] s_tuser   = '0;  // action, channel, read_ok
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // position, offset, zero pad
  logic [M_TUSER_W-1:0] m_tuser;         // out_channel, read_error
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  angle_sample_averager dut (.*);

  // Scoreboard copy of the block state and registers
  logic [ANGLE_W-1:0] base_angle [2];
  logic [15:0]        angle_sum   = '0;
  logic [CFG_W-1:0]   good_count  = '0;
  logic [CFG_W-1:0]   fail_count  = '0;
  logic [CFG_W-1:0]   phase_reads = '0;
  logic               averaging   = 1'b0;
  logic               in_burst    = 1'b0;
  logic               burst_kind  = KIND_BASELINE;
  logic               burst_chan  = 1'b0;
  logic [CFG_W-1:0]   baseline_n  = BASELINE_READS_RST;
  logic [CFG_W-1:0]   measure_n   = MEASURE_READS_RST;
  logic [CFG_W-1:0]   fail_limit  = FAILURE_LIMIT_RST;

  burst_result_t expected_bursts [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int stall_request      = 0;
  int stall_left         = 0;
  logic stall_taken      = 1'b0;
  int cycle_count        = 0;
  int mismatches         = 0;
  int reads_sent         = 0;
  int results_seen       = 0;
  int error_results      = 0;
  int reg_writes         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_request > 0 && !stall_taken) begin
      stall_left = stall_request;
      stall_taken = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    burst_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_bursts.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, actual tuser %0h tdata %0h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = expected_bursts.pop_front();
        if (want.error) error_results++;
        compare_field("out_channel", want.channel, m_tuser[0]);
        compare_field("read_error", want.error, m_tuser[1]);
        compare_field("position", want.position, m_tdata[ANGLE_W-1:0]);
        compare_field("offset", want.offset, m_tdata[ANGLE_W+OFFSET_W-1:ANGLE_W]);
        compare_field("tdata pad", '0, m_tdata[M_TDATA_W-1:ANGLE_W+OFFSET_W]);
      end
    end
  end

  task automatic accumulate_read(input angle_read_t r);
    logic [CFG_W-1:0]   n;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] avg;
    burst_result_t      res;
    if (!in_burst) begin
      burst_kind  = r.action;
      burst_chan  = r.channel;
      in_burst    = 1'b1;
      averaging   = 1'b0;
      angle_sum   = '0;
      good_count  = '0;
      fail_count  = '0;
      phase_reads = '0;
    end
    n = (burst_kind == KIND_MEASURE) ? measure_n : baseline_n;
    if (n == 0) n = CFG_W'(1);
    else if (n > MAX_READS_DEF) n = CFG_W'(MAX_READS_DEF);
    angle = {r.angle_high[HIGH_W-1:0], r.angle_low};
    if (!r.read_ok && fail_count != FAIL_SAT) fail_count++;
    if (averaging && r.read_ok) begin
      angle_sum += angle;
      good_count++;
    end
    phase_reads++;
    if (phase_reads < n) return;
    res = '0;
    res.channel = burst_chan;
    if (fail_count >= fail_limit) begin
      res.error = 1'b1;
    end else if (!averaging) begin
      averaging   = 1'b1;
      phase_reads = '0;
      if (burst_kind == KIND_MEASURE) fail_count = '0;
      return;
    end else if (good_count == 0) begin
      res.error = 1'b1;
    end else begin
      avg = ANGLE_W'(angle_sum / good_count);
      res.position = avg;
      if (burst_kind == KIND_MEASURE)
        res.offset = {1'b0, avg} - {1'b0, base_angle[burst_chan]};
      else
        base_angle[burst_chan] = avg;
    end
    in_burst = 1'b0;
    expected_bursts.push_back(res);
  endtask

  // Hold tvalid across back-to-back requests; drop it only on an idle cycle
  task automatic offer_read(input angle_read_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.angle_low, r.angle_high};
    s_tuser  <= {r.read_ok, r.channel, r.action};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_read(r);
    reads_sent++;
  endtask

  function automatic angle_read_t make_read(input logic action, input logic channel,
                                            input logic ok, input logic [7:0] high,
                                            input logic [7:0] low);
    angle_read_t r;
    r.action     = action;
    r.channel    = channel;
    r.read_ok    = ok;
    r.angle_high = high;
    r.angle_low  = low;
    return r;
  endfunction

  function automatic angle_read_t random_read(input int fail_pct);
    angle_read_t r;
    r.action     = 1'($urandom_range(1));
    r.channel    = 1'($urandom_range(1));
    r.read_ok    = ($urandom_range(99) >= fail_pct);
    r.angle_high = 8'($urandom_range(255));
    r.angle_low  = 8'($urandom_range(255));
    case ($urandom_range(7))
      0: {r.angle_high, r.angle_low} = '1;
      1: {r.angle_high, r.angle_low} = '0;
      default: ;
    endcase
    return r;
  endfunction

  // Mostly clean bursts; some with heavy failures to hit the error paths
  task automatic random_bursts(input int read_total);
    int          sent;
    int          fail_pct;
    logic        act;
    logic        chan;
    angle_read_t r;
    sent = 0;
    while (sent < read_total) begin
      act  = 1'($urandom_range(1));
      chan = 1'($urandom_range(1));
      case ($urandom_range(9))
        0:       fail_pct = $urandom_range(100, 50);
        1, 2:    fail_pct = $urandom_range(40, 10);
        default: fail_pct = $urandom_range(5);
      endcase
      do begin
        r = random_read(fail_pct);
        if (!in_burst) begin
          r.action  = act;
          r.channel = chan;
        end
        offer_read(r);
        sent++;
      end while (in_burst);
    end
  endtask

  // Finish any open burst, drain results, then let the block go idle
  task automatic settle();
    int waited;
    while (in_burst) offer_read(random_read(0));
    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_bursts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bursts.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_bursts.size());
      expected_bursts.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] base_reads,
                            input logic [CFG_W-1:0] meas_reads,
                            input logic [CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASELINE_READS;
    cfg_data  <= base_reads;
    @(posedge clk);
    cfg_index <= REG_MEASURE_READS;
    cfg_data  <= meas_reads;
    @(posedge clk);
    cfg_index <= REG_FAILURE_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    baseline_n = base_reads;
    measure_n  = meas_reads;
    fail_limit = limit;
    reg_writes += 3;
  endtask

  task automatic test_reset_values();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    random_bursts(150);
    settle();
  endtask

  task automatic test_directed_cases();
    set_config(2, 1, 2);
    // baseline on x: mid-burst kind and channel ignored, high byte masked
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b1, 8'hff, 8'hff));
    offer_read(make_read(KIND_MEASURE, 1'b1, 1'b1, 8'h12, 8'h34));
    offer_read(make_read(KIND_MEASURE, 1'b1, 1'b1, 8'hff, 8'hff));
    offer_read(make_read(KIND_BASELINE, 1'b1, 1'b1, 8'h0e, 8'h01));
    // measure on y against zero baseline
    offer_read(make_read(KIND_MEASURE, 1'b1, 1'b1, 8'h00, 8'h00));
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b1, 8'h00, 8'h00));
    // measure on x below and above its baseline
    offer_read(make_read(KIND_MEASURE, 1'b0, 1'b1, 8'h05, 8'h55));
    offer_read(make_read(KIND_MEASURE, 1'b0, 1'b1, 8'h00, 8'h00));
    offer_read(make_read(KIND_MEASURE, 1'b0, 1'b1, 8'haa, 8'haa));
    offer_read(make_read(KIND_MEASURE, 1'b0, 1'b1, 8'h0f, 8'hff));
    // discard phase fails, burst ends early on y
    offer_read(make_read(KIND_BASELINE, 1'b1, 1'b0, 8'h00, 8'h00));
    offer_read(make_read(KIND_BASELINE, 1'b1, 1'b0, 8'hff, 8'hff));
    // no good reads in the averaging phase
    offer_read(make_read(KIND_MEASURE, 1'b1, 1'b1, 8'h01, 8'h02));
    offer_read(make_read(KIND_MEASURE, 1'b1, 1'b0, 8'h03, 8'h04));
    // baseline failures carry across phases
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b0, 8'h07, 8'h77));
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b1, 8'h07, 8'h77));
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b0, 8'h07, 8'h77));
    offer_read(make_read(KIND_BASELINE, 1'b0, 1'b1, 8'h07, 8'h77));
    settle();
  endtask

  task automatic test_long_bursts();
    set_config(16, 16, 16);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    random_bursts(300);
    settle();
  endtask

  task automatic test_short_bursts();
    set_config(1, 1, 1);
    sender_idle_pct    = 80;
    receiver_stall_pct = 0;
    random_bursts(250);
    settle();
  endtask

  task automatic test_receiver_stall();
    set_config(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)),
               CFG_W'($urandom_range(16, 1)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 80;
    random_bursts(300);
    settle();
  endtask

  task automatic test_both_idle();
    set_config(3, 2, 2);
    sender_idle_pct    = 9;
    receiver_stall_pct = 9;
    random_bursts(300);
    settle();
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_config(CFG_W'($urandom_range(16, 1)), CFG_W'($urandom_range(16, 1)),
                 CFG_W'($urandom_range(16, 1)));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      random_bursts(100);
      settle();
    end
  endtask

  task automatic test_backpressure();
    set_config(2, 2, 3);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    stall_request      = 600;
    random_bursts(60);
    settle();
  endtask

  task automatic test_mixed_extremes();
    set_config(16, 1, 1);
    sender_idle_pct    = 9;
    receiver_stall_pct = 9;
    random_bursts(200);
    settle();
  endtask

  initial begin
    base_angle[0] = '0;
    base_angle[1] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_long_bursts();
    test_short_bursts();
    test_receiver_stall();
    test_both_idle();
    test_random_settings();
    test_backpressure();
    test_mixed_extremes();
    $display("covered %0d reads, %0d burst results (%0d error results), %0d register writes",
             reads_sent, results_seen, error_results, reg_writes);
    $display("idle/stall patterns and one long output hold-off; %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[angle_sample_averager.f]
design/asa_pkg.sv
design/asa_div.sv
design/angle_sample_averager.sv
dv/tb_angle_sample_averager.sv
